// ===== hw/rtl/foc_tf_pkg.sv =====
package foc_tf_pkg;

    // pipeline depth: trig/sum, products, park/clarke, scale, duty
    localparam int PIPE_DEPTH = 5;

    // fixed-point gains
    localparam logic signed [15:0] BETA_GAIN  = 16'sd18918;
    localparam logic signed [15:0] SCALE_GAIN = 16'sd28377;
    localparam logic signed [17:0] V_OFFSET   = 18'sd16384;

    // configuration register indexes
    localparam logic [1:0] CFG_VD_REFERENCE = 2'd0;
    localparam logic [1:0] CFG_VQ_REFERENCE = 2'd1;
    localparam logic [1:0] CFG_HALF_PERIOD  = 2'd2;

    // configuration reset values
    localparam logic signed [15:0] VD_RESET = 16'sd0;
    localparam logic signed [15:0] VQ_RESET = 16'sd800;
    localparam logic [14:0]        HP_RESET = 15'd1440;

    // angle quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // stage load enables from the pipeline control
    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
    } pipe_ctrl_t;

    // configuration register contents
    typedef struct packed {
        logic signed [15:0] vd_reference;
        logic signed [15:0] vq_reference;
        logic [14:0]        half_period;
    } cfg_regs_t;

    // quarter-wave sine, q15
    localparam logic [15:0] QUARTER_SINE [256] = '{
        16'h0000,16'h00C9,16'h0192,16'h025B,16'h0324,16'h03ED,16'h04B6,16'h057F,
        16'h0648,16'h0711,16'h07D9,16'h08A2,16'h096A,16'h0A33,16'h0AFB,16'h0BC4,
        16'h0C8C,16'h0D54,16'h0E1C,16'h0EE3,16'h0FAB,16'h1072,16'h113A,16'h1201,
        16'h12C8,16'h138F,16'h1455,16'h151C,16'h15E2,16'h16A8,16'h176E,16'h1833,
        16'h18F9,16'h19BE,16'h1A82,16'h1B47,16'h1C0B,16'h1CCF,16'h1D93,16'h1E57,
        16'h1F1A,16'h1FDD,16'h209F,16'h2161,16'h2223,16'h22E5,16'h23A6,16'h2467,
        16'h2528,16'h25E8,16'h26A8,16'h2767,16'h2826,16'h28E5,16'h29A3,16'h2A61,
        16'h2B1F,16'h2BDC,16'h2C99,16'h2D55,16'h2E11,16'h2ECC,16'h2F87,16'h3041,
        16'h30FB,16'h31B5,16'h326E,16'h3326,16'h33DF,16'h3496,16'h354D,16'h3604,
        16'h36BA,16'h376F,16'h3824,16'h38D9,16'h398C,16'h3A40,16'h3AF2,16'h3BA5,
        16'h3C56,16'h3D07,16'h3DB8,16'h3E68,16'h3F17,16'h3FC5,16'h4073,16'h4121,
        16'h41CE,16'h427A,16'h4325,16'h43D0,16'h447A,16'h4524,16'h45CD,16'h4675,
        16'h471C,16'h47C3,16'h4869,16'h490F,16'h49B4,16'h4A58,16'h4AFB,16'h4B9D,
        16'h4C3F,16'h4CE0,16'h4D81,16'h4E20,16'h4EBF,16'h4F5D,16'h4FFB,16'h5097,
        16'h5133,16'h51CE,16'h5268,16'h5302,16'h539B,16'h5432,16'h54C9,16'h5560,
        16'h55F5,16'h568A,16'h571D,16'h57B0,16'h5842,16'h58D3,16'h5964,16'h59F3,
        16'h5A82,16'h5B0F,16'h5B9C,16'h5C28,16'h5CB3,16'h5D3E,16'h5DC7,16'h5E4F,
        16'h5ED7,16'h5F5D,16'h5FE3,16'h6068,16'h60EB,16'h616E,16'h61F0,16'h6271,
        16'h62F1,16'h6370,16'h63EE,16'h646C,16'h64E8,16'h6563,16'h65DD,16'h6656,
        16'h66CF,16'h6746,16'h67BC,16'h6832,16'h68A6,16'h6919,16'h698B,16'h69FD,
        16'h6A6D,16'h6ADC,16'h6B4A,16'h6BB7,16'h6C23,16'h6C8E,16'h6CF8,16'h6D61,
        16'h6DC9,16'h6E30,16'h6E96,16'h6EFB,16'h6F5E,16'h6FC1,16'h7022,16'h7083,
        16'h70E2,16'h7140,16'h719D,16'h71F9,16'h7254,16'h72AE,16'h7307,16'h735E,
        16'h73B5,16'h740A,16'h745F,16'h74B2,16'h7504,16'h7555,16'h75A5,16'h75F3,
        16'h7641,16'h768D,16'h76D8,16'h7722,16'h776B,16'h77B3,16'h77FA,16'h783F,
        16'h7884,16'h78C7,16'h7909,16'h794A,16'h7989,16'h79C8,16'h7A05,16'h7A41,
        16'h7A7C,16'h7AB6,16'h7AEE,16'h7B26,16'h7B5C,16'h7B91,16'h7BC5,16'h7BF8,
        16'h7C29,16'h7C59,16'h7C88,16'h7CB6,16'h7CE3,16'h7D0E,16'h7D39,16'h7D62,
        16'h7D89,16'h7DB0,16'h7DD5,16'h7DFA,16'h7E1D,16'h7E3E,16'h7E5F,16'h7E7E,
        16'h7E9C,16'h7EB9,16'h7ED5,16'h7EEF,16'h7F09,16'h7F21,16'h7F37,16'h7F4D,
        16'h7F61,16'h7F74,16'h7F86,16'h7F97,16'h7FA6,16'h7FB4,16'h7FC1,16'h7FCD,
        16'h7FD8,16'h7FE1,16'h7FE9,16'h7FF0,16'h7FF5,16'h7FF9,16'h7FFD,16'h7FFE
    };

endpackage

// ===== hw/rtl/foc_tf_ctrl.sv =====
module foc_tf_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output foc_tf_pkg::pipe_ctrl_t  ctrl
);
    import foc_tf_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH:0]   adv;

    // a stage advances when it is empty or the stage after it advances
    assign adv[PIPE_DEPTH]     = m_ready;
    assign adv[PIPE_DEPTH-1:0] = ~valid_reg | adv[PIPE_DEPTH:1];

    // valid bits move with the data
    assign valid_next = (adv[PIPE_DEPTH-1:0] & {valid_reg[PIPE_DEPTH-2:0], s_valid})
                      | (~adv[PIPE_DEPTH-1:0] & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready   = adv[0];
    assign m_valid   = valid_reg[PIPE_DEPTH-1];
    assign ctrl.load = adv[PIPE_DEPTH-1:0];

endmodule

// ===== hw/rtl/foc_tf_trig.sv =====
module foc_tf_trig (
    input  logic                    aclk,
    input  foc_tf_pkg::pipe_ctrl_t  ctrl,
    input  logic [15:0]             angle,
    output logic signed [15:0]      sine,
    output logic signed [15:0]      cosine
);
    import foc_tf_pkg::*;

    logic [1:0]         quad;
    logic [7:0]         idx;
    logic signed [15:0] t_fwd;
    logic signed [15:0] t_rev;
    logic signed [15:0] sine_next;
    logic signed [15:0] cosine_next;
    logic signed [15:0] sine_reg;
    logic signed [15:0] cosine_reg;

    assign quad  = angle[15:14];
    assign idx   = angle[13:6];
    assign t_fwd = $signed(QUARTER_SINE[idx]);
    assign t_rev = $signed(QUARTER_SINE[~idx]);

    // quadrant folding of the quarter-wave table
    always_comb begin
        case (quad)
            QUAD_0: begin
                sine_next   = t_fwd;
                cosine_next = t_rev;
            end
            QUAD_1: begin
                sine_next   = t_rev;
                cosine_next = -t_fwd;
            end
            QUAD_2: begin
                sine_next   = -t_fwd;
                cosine_next = -t_rev;
            end
            QUAD_3: begin
                sine_next   = -t_rev;
                cosine_next = t_fwd;
            end
            default: begin
                sine_next   = -t_rev;
                cosine_next = t_fwd;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

// ===== hw/rtl/foc_tf_park.sv =====
module foc_tf_park (
    input  logic                    aclk,
    input  foc_tf_pkg::pipe_ctrl_t  ctrl,
    input  logic signed [15:0]      current_a,
    input  logic signed [15:0]      current_b,
    input  logic signed [15:0]      sine,
    input  logic signed [15:0]      cosine,
    output logic signed [17:0]      current_d,
    output logic signed [17:0]      current_q
);
    import foc_tf_pkg::*;

    logic signed [15:0] ia0_reg;
    logic signed [17:0] sum0_reg;
    logic signed [17:0] sum0_next;

    logic signed [33:0] beta_prod;
    logic signed [31:0] iacs_prod;
    logic signed [31:0] iasn_prod;
    logic signed [17:0] ibeta1_reg;
    logic signed [16:0] iacs1_reg;
    logic signed [16:0] iasn1_reg;
    logic signed [15:0] sin1_reg;
    logic signed [15:0] cos1_reg;

    logic signed [33:0] bsn_prod;
    logic signed [33:0] bcs_prod;
    logic signed [17:0] id_next;
    logic signed [17:0] iq_next;
    logic signed [17:0] id2_reg;
    logic signed [17:0] iq2_reg;
    logic signed [17:0] id3_reg;
    logic signed [17:0] iq3_reg;
    logic signed [17:0] id4_reg;
    logic signed [17:0] iq4_reg;

    // stage 0: ia + 2*ib
    assign sum0_next = {{2{current_a[15]}}, current_a} + {current_b[15], current_b, 1'b0};

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            ia0_reg  <= current_a;
            sum0_reg <= sum0_next;
        end
    end

    // stage 1: clarke beta and alpha products
    assign beta_prod = sum0_reg * BETA_GAIN;
    assign iacs_prod = ia0_reg * cosine;
    assign iasn_prod = ia0_reg * sine;

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            ibeta1_reg <= beta_prod[32:15];
            iacs1_reg  <= iacs_prod[31:15];
            iasn1_reg  <= iasn_prod[31:15];
            sin1_reg   <= sine;
            cos1_reg   <= cosine;
        end
    end

    // stage 2: park rotation
    assign bsn_prod = ibeta1_reg * sin1_reg;
    assign bcs_prod = ibeta1_reg * cos1_reg;
    assign id_next  = {iacs1_reg[16], iacs1_reg} + bsn_prod[32:15];
    assign iq_next  = bcs_prod[32:15] - {iasn1_reg[16], iasn1_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            id2_reg <= id_next;
            iq2_reg <= iq_next;
        end
    end

    // stages 3 and 4: delay to line up with the duty path
    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            id3_reg <= id2_reg;
            iq3_reg <= iq2_reg;
        end
        if (ctrl.load[4]) begin
            id4_reg <= id3_reg;
            iq4_reg <= iq3_reg;
        end
    end

    assign current_d = id4_reg;
    assign current_q = iq4_reg;

endmodule

// ===== hw/rtl/foc_tf_vgen.sv =====
module foc_tf_vgen (
    input  logic                    aclk,
    input  foc_tf_pkg::pipe_ctrl_t  ctrl,
    input  foc_tf_pkg::cfg_regs_t   cfg,
    input  logic signed [15:0]      sine,
    input  logic signed [15:0]      cosine,
    output logic [15:0]             duty_a,
    output logic [15:0]             duty_b,
    output logic [15:0]             duty_c
);
    import foc_tf_pkg::*;

    logic signed [31:0] vdcs_prod;
    logic signed [31:0] vqsn_prod;
    logic signed [31:0] vqcs_prod;
    logic signed [31:0] vdsn_prod;
    logic signed [17:0] valpha1_reg;
    logic signed [17:0] vbeta1_reg;

    logic signed [33:0] tb_prod;
    logic signed [17:0] tb;
    logic signed [17:0] va2_reg;
    logic signed [17:0] vb2_reg;
    logic signed [17:0] vc2_reg;

    logic signed [33:0] va_prod;
    logic signed [33:0] vb_prod;
    logic signed [33:0] vc_prod;
    logic signed [17:0] va3_reg;
    logic signed [17:0] vb3_reg;
    logic signed [17:0] vc3_reg;

    logic signed [15:0] hp_s;
    logic signed [33:0] da_prod;
    logic signed [33:0] db_prod;
    logic signed [33:0] dc_prod;
    logic signed [18:0] da_sum;
    logic signed [18:0] db_sum;
    logic signed [18:0] dc_sum;
    logic [15:0]        duty_a_reg;
    logic [15:0]        duty_b_reg;
    logic [15:0]        duty_c_reg;

    // clamp a compare value to 0..65535
    function automatic logic [15:0] sat_duty(input logic signed [18:0] d);
        logic [15:0] r;
        if (d[18]) begin
            r = '0;
        end else if (d[17:16] != 2'b00) begin
            r = '1;
        end else begin
            r = d[15:0];
        end
        return r;
    endfunction

    // stage 1: inverse park
    assign vdcs_prod = cfg.vd_reference * cosine;
    assign vqsn_prod = cfg.vq_reference * sine;
    assign vqcs_prod = cfg.vq_reference * cosine;
    assign vdsn_prod = cfg.vd_reference * sine;

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            valpha1_reg <= {vdcs_prod[31], vdcs_prod[31:15]}
                         - {vqsn_prod[31], vqsn_prod[31:15]};
            vbeta1_reg  <= {vqcs_prod[31], vqcs_prod[31:15]}
                         + {vdsn_prod[31], vdsn_prod[31:15]};
        end
    end

    // stage 2: inverse clarke
    assign tb_prod = vbeta1_reg * SCALE_GAIN;
    assign tb      = tb_prod[32:15];

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            va2_reg <= valpha1_reg;
            vb2_reg <= (valpha1_reg >>> 1) + tb;
            vc2_reg <= (valpha1_reg >>> 1) - tb;
        end
    end

    // stage 3: scale and offset
    assign va_prod = va2_reg * SCALE_GAIN;
    assign vb_prod = vb2_reg * SCALE_GAIN;
    assign vc_prod = vc2_reg * SCALE_GAIN;

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            va3_reg <= va_prod[32:15] + V_OFFSET;
            vb3_reg <= vb_prod[32:15] + V_OFFSET;
            vc3_reg <= vc_prod[32:15] + V_OFFSET;
        end
    end

    // stage 4: compare values around the half period
    assign hp_s    = $signed({1'b0, cfg.half_period});
    assign da_prod = va3_reg * hp_s;
    assign db_prod = vb3_reg * hp_s;
    assign dc_prod = vc3_reg * hp_s;
    assign da_sum  = da_prod[33:15] + {4'b0000, cfg.half_period};
    assign db_sum  = db_prod[33:15] + {4'b0000, cfg.half_period};
    assign dc_sum  = dc_prod[33:15] + {4'b0000, cfg.half_period};

    always_ff @(posedge aclk) begin
        if (ctrl.load[4]) begin
            duty_a_reg <= sat_duty(da_sum);
            duty_b_reg <= sat_duty(db_sum);
            duty_c_reg <= sat_duty(dc_sum);
        end
    end

    assign duty_a = duty_a_reg;
    assign duty_b = duty_b_reg;
    assign duty_c = duty_c_reg;

endmodule

// ===== hw/rtl/foc_transform_datapath.sv =====
// field-oriented-control transform datapath
// input channel (s_valid/s_ready): two phase currents and an electrical angle
// per transaction; the block returns the park-frame currents current_d and
// current_q and three pwm compare values on the result channel (m_valid/m_ready),
// one result transaction for each input transaction, in order.
// the voltage commands and the pwm half period are set through the cfg_ write
// channel (index 0 vd_reference, 1 vq_reference, 2 half_period, 3 ignored);
// cfg_ready is always high and writes belong between bursts of traffic.
// an input transaction passes through the registered stages table lookup and
// clarke sum, first products, park rotation / inverse clarke, scale and duty
// on its way to the result channel.
// throughput is one transaction per clock while the result channel is not
// stalled; stages 1 to 4 each hold one registered multiplier level, and a stage
// moves on whenever the stage after it can take its contents.
// when the receiver stalls, filled stages hold and empty stages keep filling;
// s_ready falls only once the whole pipeline is full behind a stalled output.
// synchronous active-low reset empties the pipeline and loads the register
// defaults (vd 0, vq 800, half period 1440).
module foc_transform_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_current_a,
    input  logic signed [15:0] s_current_b,
    input  logic [15:0]        s_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_current_d,
    output logic signed [17:0] m_current_q,
    output logic [15:0]        m_duty_a,
    output logic [15:0]        m_duty_b,
    output logic [15:0]        m_duty_c,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import foc_tf_pkg::*;

    pipe_ctrl_t         ctrl;
    cfg_regs_t          cfg_reg;
    cfg_regs_t          cfg_next;
    logic signed [15:0] sine;
    logic signed [15:0] cosine;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_VD_REFERENCE: cfg_next.vd_reference = $signed(cfg_data);
                CFG_VQ_REFERENCE: cfg_next.vq_reference = $signed(cfg_data);
                CFG_HALF_PERIOD:  cfg_next.half_period  = cfg_data[14:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vd_reference <= VD_RESET;
            cfg_reg.vq_reference <= VQ_RESET;
            cfg_reg.half_period  <= HP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline valid tracking and stage enables
    foc_tf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    // sine and cosine of the angle
    foc_tf_trig u_trig (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .angle  (s_angle),
        .sine   (sine),
        .cosine (cosine)
    );

    // clarke and park of the phase currents
    foc_tf_park u_park (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .current_a (s_current_a),
        .current_b (s_current_b),
        .sine      (sine),
        .cosine    (cosine),
        .current_d (m_current_d),
        .current_q (m_current_q)
    );

    // inverse park, inverse clarke and duty mapping
    foc_tf_vgen u_vgen (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .cfg    (cfg_reg),
        .sine   (sine),
        .cosine (cosine),
        .duty_a (m_duty_a),
        .duty_b (m_duty_b),
        .duty_c (m_duty_c)
    );

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    // input back-pressure only comes from a stalled result
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("s_ready low without a stalled result");

    // an accepted transaction reaches the output when the output does not stall
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_ready) ##1 m_ready ##1 m_ready ##1 m_ready
        ##1 m_ready |=> m_valid)
        else $error("result missing after pipeline latency");

endmodule

// ===== tb/foc_checker.sv =====
`timescale 1ns / 100ps

module foc_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_current_a,
    input  logic signed [15:0] s_current_b,
    input  logic [15:0]        s_angle,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [17:0] m_current_d,
    input  logic signed [17:0] m_current_q,
    input  logic [15:0]        m_duty_a,
    input  logic [15:0]        m_duty_b,
    input  logic [15:0]        m_duty_c,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 mismatches,
    output int                 outstanding
);
    import foc_tf_pkg::*;

    // fixed-point gains of the transform chain
    localparam longint ONE_OVER_SQRT3 = 18918;
    localparam longint SQRT3_OVER_2   = 28377;
    localparam longint VOLT_OFFSET    = 16384;

    // quarter-wave sine, q15, 256 steps over 0..pi/2
    localparam int SINE_Q15 [256] = '{
        'h0000,'h00C9,'h0192,'h025B,'h0324,'h03ED,'h04B6,'h057F,
        'h0648,'h0711,'h07D9,'h08A2,'h096A,'h0A33,'h0AFB,'h0BC4,
        'h0C8C,'h0D54,'h0E1C,'h0EE3,'h0FAB,'h1072,'h113A,'h1201,
        'h12C8,'h138F,'h1455,'h151C,'h15E2,'h16A8,'h176E,'h1833,
        'h18F9,'h19BE,'h1A82,'h1B47,'h1C0B,'h1CCF,'h1D93,'h1E57,
        'h1F1A,'h1FDD,'h209F,'h2161,'h2223,'h22E5,'h23A6,'h2467,
        'h2528,'h25E8,'h26A8,'h2767,'h2826,'h28E5,'h29A3,'h2A61,
        'h2B1F,'h2BDC,'h2C99,'h2D55,'h2E11,'h2ECC,'h2F87,'h3041,
        'h30FB,'h31B5,'h326E,'h3326,'h33DF,'h3496,'h354D,'h3604,
        'h36BA,'h376F,'h3824,'h38D9,'h398C,'h3A40,'h3AF2,'h3BA5,
        'h3C56,'h3D07,'h3DB8,'h3E68,'h3F17,'h3FC5,'h4073,'h4121,
        'h41CE,'h427A,'h4325,'h43D0,'h447A,'h4524,'h45CD,'h4675,
        'h471C,'h47C3,'h4869,'h490F,'h49B4,'h4A58,'h4AFB,'h4B9D,
        'h4C3F,'h4CE0,'h4D81,'h4E20,'h4EBF,'h4F5D,'h4FFB,'h5097,
        'h5133,'h51CE,'h5268,'h5302,'h539B,'h5432,'h54C9,'h5560,
        'h55F5,'h568A,'h571D,'h57B0,'h5842,'h58D3,'h5964,'h59F3,
        'h5A82,'h5B0F,'h5B9C,'h5C28,'h5CB3,'h5D3E,'h5DC7,'h5E4F,
        'h5ED7,'h5F5D,'h5FE3,'h6068,'h60EB,'h616E,'h61F0,'h6271,
        'h62F1,'h6370,'h63EE,'h646C,'h64E8,'h6563,'h65DD,'h6656,
        'h66CF,'h6746,'h67BC,'h6832,'h68A6,'h6919,'h698B,'h69FD,
        'h6A6D,'h6ADC,'h6B4A,'h6BB7,'h6C23,'h6C8E,'h6CF8,'h6D61,
        'h6DC9,'h6E30,'h6E96,'h6EFB,'h6F5E,'h6FC1,'h7022,'h7083,
        'h70E2,'h7140,'h719D,'h71F9,'h7254,'h72AE,'h7307,'h735E,
        'h73B5,'h740A,'h745F,'h74B2,'h7504,'h7555,'h75A5,'h75F3,
        'h7641,'h768D,'h76D8,'h7722,'h776B,'h77B3,'h77FA,'h783F,
        'h7884,'h78C7,'h7909,'h794A,'h7989,'h79C8,'h7A05,'h7A41,
        'h7A7C,'h7AB6,'h7AEE,'h7B26,'h7B5C,'h7B91,'h7BC5,'h7BF8,
        'h7C29,'h7C59,'h7C88,'h7CB6,'h7CE3,'h7D0E,'h7D39,'h7D62,
        'h7D89,'h7DB0,'h7DD5,'h7DFA,'h7E1D,'h7E3E,'h7E5F,'h7E7E,
        'h7E9C,'h7EB9,'h7ED5,'h7EEF,'h7F09,'h7F21,'h7F37,'h7F4D,
        'h7F61,'h7F74,'h7F86,'h7F97,'h7FA6,'h7FB4,'h7FC1,'h7FCD,
        'h7FD8,'h7FE1,'h7FE9,'h7FF0,'h7FF5,'h7FF9,'h7FFD,'h7FFE
    };

    typedef struct {
        logic signed [17:0] cur_d;
        logic signed [17:0] cur_q;
        logic [15:0]        duty_a;
        logic [15:0]        duty_b;
        logic [15:0]        duty_c;
    } foc_result_t;

    // shadow of the voltage commands and pwm half period
    logic signed [15:0] vd_cmd;
    logic signed [15:0] vq_cmd;
    logic [14:0]        pwm_half;

    foc_result_t park_pwm_q [$];
    int          fail_count = 0;
    int          pending_count = 0;

    assign mismatches  = fail_count;
    assign outstanding = pending_count;

    // compare value around the half period, clipped to 16 bits
    function automatic logic [15:0] pwm_compare(input longint volt);
        longint hp;
        longint d;
        hp = longint'(pwm_half);
        d = ((volt * hp) >>> 15) + hp;
        if (d < 0)
            d = 0;
        if (d > 65535)
            d = 65535;
        return 16'(d);
    endfunction

    // clarke + park of the currents, inverse park + clarke of the commands
    function automatic foc_result_t transform_sample(input logic signed [15:0] ia_in,
                                                     input logic signed [15:0] ib_in,
                                                     input logic [15:0] ang);
        foc_result_t r;
        longint ia, ib, vd, vq;
        longint fwd, rev, sn, cs;
        longint ibeta, id, iq, valpha, vbeta, tb, va, vb, vc;
        logic [7:0] idx;
        ia = ia_in;
        ib = ib_in;
        vd = vd_cmd;
        vq = vq_cmd;
        idx = ang[13:6];
        fwd = SINE_Q15[idx];
        rev = SINE_Q15[8'hFF - idx];
        // quadrant folding of the quarter-wave table
        case (ang[15:14])
            QUAD_0: begin sn = fwd;  cs = rev;  end
            QUAD_1: begin sn = rev;  cs = -fwd; end
            QUAD_2: begin sn = -fwd; cs = -rev; end
            default: begin sn = -rev; cs = fwd; end
        endcase
        ibeta = ((ia + 2 * ib) * ONE_OVER_SQRT3) >>> 15;
        id = ((ia * cs) >>> 15) + ((ibeta * sn) >>> 15);
        iq = ((ibeta * cs) >>> 15) - ((ia * sn) >>> 15);
        valpha = ((vd * cs) >>> 15) - ((vq * sn) >>> 15);
        vbeta  = ((vq * cs) >>> 15) + ((vd * sn) >>> 15);
        tb = (vbeta * SQRT3_OVER_2) >>> 15;
        va = valpha;
        vb = (valpha >>> 1) + tb;
        vc = (valpha >>> 1) - tb;
        va = ((va * SQRT3_OVER_2) >>> 15) + VOLT_OFFSET;
        vb = ((vb * SQRT3_OVER_2) >>> 15) + VOLT_OFFSET;
        vc = ((vc * SQRT3_OVER_2) >>> 15) + VOLT_OFFSET;
        r.cur_d  = 18'(id);
        r.cur_q  = 18'(iq);
        r.duty_a = pwm_compare(va);
        r.duty_b = pwm_compare(vb);
        r.duty_c = pwm_compare(vc);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    // watch the three channels
    always @(posedge aclk) begin
        foc_result_t want;
        if (!aresetn) begin
            vd_cmd = 16'sd0;
            vq_cmd = 16'sd800;
            pwm_half = 15'd1440;
            park_pwm_q.delete();
        end else begin
            // register write transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_VD_REFERENCE: vd_cmd = cfg_data;
                    CFG_VQ_REFERENCE: vq_cmd = cfg_data;
                    CFG_HALF_PERIOD:  pwm_half = cfg_data[14:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest expectation
            if (m_valid && m_ready) begin
                if (park_pwm_q.size() == 0) begin
                    report_mismatch("result transactions pending", 1, 0);
                end else begin
                    want = park_pwm_q.pop_front();
                    if (m_current_d !== want.cur_d)
                        report_mismatch("current_d", m_current_d, want.cur_d);
                    if (m_current_q !== want.cur_q)
                        report_mismatch("current_q", m_current_q, want.cur_q);
                    if (m_duty_a !== want.duty_a)
                        report_mismatch("duty_a", m_duty_a, want.duty_a);
                    if (m_duty_b !== want.duty_b)
                        report_mismatch("duty_b", m_duty_b, want.duty_b);
                    if (m_duty_c !== want.duty_c)
                        report_mismatch("duty_c", m_duty_c, want.duty_c);
                end
            end
            // input transaction
            if (s_valid && s_ready)
                park_pwm_q.push_back(transform_sample(s_current_a, s_current_b, s_angle));
        end
        pending_count = park_pwm_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import foc_tf_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SAMPLES_PER_SETTING = 172;
    localparam int SETTING_COUNT = 6;

    localparam logic signed [15:0] CURRENT_EDGES [4] = '{
        16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0000
    };

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_current_a = '0;
    logic signed [15:0] s_current_b = '0;
    logic [15:0]        s_angle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [17:0] m_current_d;
    logic signed [17:0] m_current_q;
    logic [15:0]        m_duty_a;
    logic [15:0]        m_duty_b;
    logic [15:0]        m_duty_c;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    int mismatches;
    int outstanding;
    int tx_idle_pct = 26;
    int rx_idle_pct = 68;
    int samples_sent = 0;
    int settings_used = 1;

    foc_transform_datapath uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_current_a (s_current_a),
        .s_current_b (s_current_b),
        .s_angle     (s_angle),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_current_d (m_current_d),
        .m_current_q (m_current_q),
        .m_duty_a    (m_duty_a),
        .m_duty_b    (m_duty_b),
        .m_duty_c    (m_duty_c),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    foc_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_current_a (s_current_a),
        .s_current_b (s_current_b),
        .s_angle     (s_angle),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_current_d (m_current_d),
        .m_current_q (m_current_q),
        .m_duty_a    (m_duty_a),
        .m_duty_b    (m_duty_b),
        .m_duty_c    (m_duty_c),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one sample transaction, with a random lead-in gap
    task automatic send_sample(input logic signed [15:0] ia, input logic signed [15:0] ib,
                               input logic [15:0] ang);
        logic taken;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_current_a <= ia;
        s_current_b <= ib;
        s_angle <= ang;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        samples_sent++;
    endtask

    task automatic send_random_sample();
        int mode;
        logic signed [15:0] ia;
        logic signed [15:0] ib;
        mode = $urandom_range(99);
        if (mode < 70) begin
            ia = 16'($urandom);
            ib = 16'($urandom);
        end else if (mode < 85) begin
            ia = 16'(int'($urandom_range(511)) - 256);
            ib = 16'(int'($urandom_range(511)) - 256);
        end else begin
            ia = CURRENT_EDGES[$urandom_range(3)];
            ib = CURRENT_EDGES[$urandom_range(3)];
        end
        send_sample(ia, ib, 16'($urandom));
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    // hold off the sender until the pipeline has emptied
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [15:0] vd, input logic [15:0] vq,
                                 input logic [15:0] hp);
        wait_drained();
        write_register(CFG_VD_REFERENCE, vd);
        write_register(CFG_VQ_REFERENCE, vq);
        write_register(CFG_HALF_PERIOD, hp);
        write_register(CFG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    // edge-case samples under the reset settings
    localparam logic signed [15:0] EDGE_A [12] = '{
        16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
        16'sh0001, 16'sh7FFF, 16'sh8000, 16'sh1234, 16'shFFFF, 16'sh8000
    };
    localparam logic signed [15:0] EDGE_B [12] = '{
        16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
        16'sh0000, 16'sh7FFF, 16'sh8000, 16'shEDCC, 16'sh0001, 16'sh7FFF
    };
    localparam logic [15:0] EDGE_ANGLE [12] = '{
        16'h0000, 16'hFFFF, 16'h003F, 16'h3FC0, 16'h4000, 16'h7FFF,
        16'h8000, 16'hBFC0, 16'hC000, 16'h2000, 16'h6000, 16'hE03F
    };
    // angles that drive the compare values into saturation
    localparam logic [15:0] SAT_ANGLE [6] = '{
        16'h0000, 16'h2000, 16'h6000, 16'hA000, 16'hE000, 16'hFFFF
    };

    initial begin
        int guard;
        logic [15:0] vd_pick;
        logic [15:0] vq_pick;
        logic [15:0] hp_pick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed samples, reset register values
        for (int i = 0; i < 12; i++)
            send_sample(EDGE_A[i], EDGE_B[i], EDGE_ANGLE[i]);

        // full-scale commands and half period push the duties past 65535
        apply_setting(16'h7FFF, 16'h7FFF, 16'h7FFF);
        for (int i = 0; i < 6; i++)
            send_sample(EDGE_A[i], EDGE_B[i], SAT_ANGLE[i]);

        // random traffic over several register settings
        for (int phase = 0; phase < SETTING_COUNT; phase++) begin
            case (phase)
                0: begin vd_pick = 16'h8000; vq_pick = 16'h7FFF; hp_pick = 16'h7FFF; end
                1: begin vd_pick = 16'h7FFF; vq_pick = 16'h8000; hp_pick = 16'h0000; end
                2: begin vd_pick = 16'($urandom); vq_pick = 16'($urandom); hp_pick = 16'hFFFF; end
                4: begin vd_pick = 16'h0000; vq_pick = 16'h0000; hp_pick = 16'($urandom); end
                default: begin
                    vd_pick = 16'($urandom);
                    vq_pick = 16'($urandom);
                    hp_pick = 16'($urandom);
                end
            endcase
            if (phase < 2) begin
                tx_idle_pct = 26;
                rx_idle_pct = 68;
            end else if (phase < 4) begin
                tx_idle_pct = 68;
                rx_idle_pct = 26;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            apply_setting(vd_pick, vq_pick, hp_pick);
            for (int n = 0; n < SAMPLES_PER_SETTING; n++)
                send_random_sample();
        end

        // drain
        s_valid <= 1'b0;
        guard = 0;
        do begin
            @(negedge aclk);
            guard++;
        end while (outstanding != 0 && guard < 20000);
        repeat (4 * PIPE_DEPTH) @(posedge aclk);

        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        $display("sent %0d sample transactions under %0d register settings", samples_sent,
                 settings_used);
        $display("covered quadrant edges, full-scale currents, duty clipping, ignored index");
        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #(3_000_000);
        $display("simulation timed out");
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/foc_tf_pkg.sv
hw/rtl/foc_tf_ctrl.sv
hw/rtl/foc_tf_trig.sv
hw/rtl/foc_tf_park.sv
hw/rtl/foc_tf_vgen.sv
hw/rtl/foc_transform_datapath.sv
tb/foc_checker.sv
tb/tb.sv
